// ----- hdl/sbmt_pkg.sv -----
// sbmt_pkg: shared constants, register codes and the per-item tracking record
// of the box separating-axis block. No dependencies.
`default_nettype none

package sbmt_pkg;

   // axis register word: x component in the upper half, y in the lower half
   localparam int AXIS_WORD_W  = 32;
   localparam int COMP_W       = 16;
   localparam int COMP_FRAC    = 14;

   // overlap is kept with 18 fraction bits, coordinates carry 4
   localparam int OV_FRAC      = 18;
   localparam int COORD_FRAC   = 4;
   localparam int PUSH_SHIFT   = OV_FRAC + COMP_FRAC - COORD_FRAC;

   // overlap limit of 1000 pixels, exact in 28 unsigned bits
   localparam int LIMIT_PIXELS = 1000;
   localparam int BEST_W       = 28;
   localparam logic [BEST_W-1:0] LIMIT_OV = BEST_W'(LIMIT_PIXELS * (2 ** OV_FRAC));

   // configuration port
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int AXIS_COUNT_W  = 3;
   localparam int NUM_AXIS_REGS = 4;
   localparam int CHOSEN_W      = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_AXIS_COUNT = 3'd0,
      REG_AXIS_ZERO  = 3'd1,
      REG_AXIS_ONE   = 3'd2,
      REG_AXIS_TWO   = 3'd3,
      REG_AXIS_THREE = 3'd4
   } reg_index_type;

   localparam logic [AXIS_COUNT_W-1:0] AXIS_COUNT_RESET = 3'd4;
   // (1,0), (0,1), (-1,0), (0,-1)
   localparam logic [NUM_AXIS_REGS-1:0][AXIS_WORD_W-1:0] AXIS_RESET = {
      32'h0000_C000, 32'hC000_0000, 32'h0000_4000, 32'h4000_0000
   };

   // edge positions inside one packed item; box B follows box A
   localparam int E_LEFT     = 0;
   localparam int E_RIGHT    = 1;
   localparam int E_TOP      = 2;
   localparam int E_BOTTOM   = 3;
   localparam int BOX_EDGES  = 4;
   localparam int EDGE_COUNT = 8;

   // running search state handed from cell to cell
   typedef struct packed {
      logic                   sep;   // some axis separates the boxes
      logic [BEST_W-1:0]      best;  // least overlap so far
      logic [AXIS_WORD_W-1:0] axis;  // axis word of the kept axis
   } track_type;

endpackage

`default_nettype wire

// ----- hdl/sbmt_if.sv -----
// sbmt_req_if and sbmt_rsp_if: valid/ready channels of the box separating-axis
// block. Depends on sbmt_pkg for the chosen-axis width.
`default_nettype none

interface sbmt_req_if #(parameter int COORD_BITS = 20);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] a_left;
   logic signed [COORD_BITS-1:0] a_right;
   logic signed [COORD_BITS-1:0] a_top;
   logic signed [COORD_BITS-1:0] a_bottom;
   logic signed [COORD_BITS-1:0] b_left;
   logic signed [COORD_BITS-1:0] b_right;
   logic signed [COORD_BITS-1:0] b_top;
   logic signed [COORD_BITS-1:0] b_bottom;

   modport source (
      output valid, a_left, a_right, a_top, a_bottom, b_left, b_right, b_top, b_bottom,
      input  ready
   );
   modport sink (
      input  valid, a_left, a_right, a_top, a_bottom, b_left, b_right, b_top, b_bottom,
      output ready
   );
endinterface

interface sbmt_rsp_if #(parameter int COORD_BITS = 20);
   logic                                 valid;
   logic                                 ready;
   logic signed [COORD_BITS-1:0]         push_x;
   logic signed [COORD_BITS-1:0]         push_y;
   logic                                 collided;
   logic [sbmt_pkg::CHOSEN_W-1:0]        chosen_axis;

   modport source (
      output valid, push_x, push_y, collided, chosen_axis,
      input  ready
   );
   modport sink (
      input  valid, push_x, push_y, collided, chosen_axis,
      output ready
   );
endinterface

`default_nettype wire

// ----- hdl/sat_box_min_translation_top.sv -----
// sat_box_min_translation_top: separating-axis test and least translation for
// two axis-aligned boxes. Depends on sbmt_pkg, sbmt_if, sbmt_cell, sbmt_push.
//
//   channel  dir  handshake          payload
//   req_ch   in   valid / ready      a_* and b_* edges, signed Q16.4
//   rsp_ch   out  valid / ready      push_x, push_y, collided, chosen_axis
//   csr_*    in   csr_we (no wait)   csr_index, csr_wdata
//
// Throughput is one item per cycle while rsp_ch.ready is high. Each
// axis cell holds three register stages (products, projection bounds,
// decision) and the push unit two (scale, truncate and saturate).
// Reset clears the stage valid bits and loads the axis registers with
// (1,0), (0,1), (-1,0), (0,-1) and an axis count of four.
// Every stage advances on its own when empty, so bubbles close up behind a
// stalled result and req_ch.ready stays high until the chain is full.
`default_nettype none

module sat_box_min_translation_top #(
   parameter int MAX_AXES   = 4,
   parameter int COORD_BITS = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   sbmt_req_if.sink                            req_ch,
   sbmt_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [sbmt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sbmt_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;

   // configuration registers
   logic [sbmt_pkg::AXIS_COUNT_W-1:0] axis_count_ff;
   logic [sbmt_pkg::AXIS_WORD_W-1:0]  axis_word [MAX_AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_count_ff <= sbmt_pkg::AXIS_COUNT_RESET;
      end else if (csr_we && csr_index == sbmt_pkg::REG_AXIS_COUNT) begin
         axis_count_ff <= csr_wdata[sbmt_pkg::AXIS_COUNT_W-1:0];
      end
   end

   // axes past the register list stay at (0,0) and take no writes
   for (genvar g = 0; g < MAX_AXES; g++) begin : g_axis
      if (g < sbmt_pkg::NUM_AXIS_REGS) begin : g_reg
         logic [sbmt_pkg::AXIS_WORD_W-1:0] axis_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               axis_ff <= sbmt_pkg::AXIS_RESET[g];
            end else if (csr_we &&
                         csr_index == sbmt_pkg::CSR_IDX_W'(sbmt_pkg::REG_AXIS_ZERO + g)) begin
               axis_ff <= csr_wdata;
            end
         end
         assign axis_word[g] = axis_ff;
      end else begin : g_none
         assign axis_word[g] = '0;
      end
   end

   // chain links; link 0 is the request side
   logic                                            ch_valid [MAX_AXES+1];
   logic                                            ch_ready [MAX_AXES+1];
   logic [sbmt_pkg::EDGE_COUNT-1:0][COORD_BITS-1:0] ch_edges [MAX_AXES+1];
   sbmt_pkg::track_type                             ch_track [MAX_AXES+1];
   logic [IDX_W-1:0]                                ch_idx   [MAX_AXES+1];

   // pack the edges; search starts at the limit with axis 0 kept
   assign ch_valid[0] = req_ch.valid;
   assign req_ch.ready = ch_ready[0];
   assign ch_edges[0][sbmt_pkg::E_LEFT]   = req_ch.a_left;
   assign ch_edges[0][sbmt_pkg::E_RIGHT]  = req_ch.a_right;
   assign ch_edges[0][sbmt_pkg::E_TOP]    = req_ch.a_top;
   assign ch_edges[0][sbmt_pkg::E_BOTTOM] = req_ch.a_bottom;
   assign ch_edges[0][sbmt_pkg::BOX_EDGES + sbmt_pkg::E_LEFT]   = req_ch.b_left;
   assign ch_edges[0][sbmt_pkg::BOX_EDGES + sbmt_pkg::E_RIGHT]  = req_ch.b_right;
   assign ch_edges[0][sbmt_pkg::BOX_EDGES + sbmt_pkg::E_TOP]    = req_ch.b_top;
   assign ch_edges[0][sbmt_pkg::BOX_EDGES + sbmt_pkg::E_BOTTOM] = req_ch.b_bottom;
   assign ch_track[0].sep  = 1'b0;
   assign ch_track[0].best = sbmt_pkg::LIMIT_OV;
   assign ch_track[0].axis = axis_word[0];
   assign ch_idx[0]        = '0;

   for (genvar g = 0; g < MAX_AXES; g++) begin : g_cell
      logic active;
      // axis counts past MAX_AXES saturate, so only "count above index" matters
      assign active = {1'b0, axis_count_ff} > (sbmt_pkg::AXIS_COUNT_W + 1)'(g);

      sbmt_cell #(
         .COORD_BITS (COORD_BITS),
         .IDX_W      (IDX_W),
         .CELL_IDX   (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .active    (active),
         .axis_word (axis_word[g]),
         .up_valid  (ch_valid[g]),
         .up_ready  (ch_ready[g]),
         .up_edges  (ch_edges[g]),
         .up_track  (ch_track[g]),
         .up_idx    (ch_idx[g]),
         .dn_valid  (ch_valid[g+1]),
         .dn_ready  (ch_ready[g+1]),
         .dn_edges  (ch_edges[g+1]),
         .dn_track  (ch_track[g+1]),
         .dn_idx    (ch_idx[g+1])
      );
   end

   sbmt_push #(
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W)
   ) u_push (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (ch_valid[MAX_AXES]),
      .up_ready    (ch_ready[MAX_AXES]),
      .up_track    (ch_track[MAX_AXES]),
      .up_idx      (ch_idx[MAX_AXES]),
      .dn_valid    (rsp_ch.valid),
      .dn_ready    (rsp_ch.ready),
      .push_x      (rsp_ch.push_x),
      .push_y      (rsp_ch.push_y),
      .collided    (rsp_ch.collided),
      .chosen_axis (rsp_ch.chosen_axis)
   );

   // no result leaves in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result valid right after reset");

   // separated boxes carry a zero result
   a_sep_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.collided) |->
         (rsp_ch.push_x == '0 && rsp_ch.push_y == '0 && rsp_ch.chosen_axis == '0))
      else $error("separated result not zero");

   // the kept overlap never grows past the starting limit
   a_best_limit: assert property (@(posedge clock) disable iff (reset)
      ch_valid[MAX_AXES] |-> (ch_track[MAX_AXES].best <= sbmt_pkg::LIMIT_OV))
      else $error("kept overlap above limit");

endmodule

`default_nettype wire

// ----- hdl/sbmt_cell.sv -----
// sbmt_cell: one axis of the separating-axis chain, three register stages
// (products, projection bounds, decision). Depends on sbmt_pkg.
`default_nettype none

module sbmt_cell #(
   parameter int COORD_BITS = 20,
   parameter int IDX_W      = 2,
   parameter int CELL_IDX   = 0
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               active,
   input  logic [sbmt_pkg::AXIS_WORD_W-1:0]                   axis_word,
   input  logic                                               up_valid,
   output logic                                               up_ready,
   input  logic [sbmt_pkg::EDGE_COUNT-1:0][COORD_BITS-1:0]    up_edges,
   input  sbmt_pkg::track_type                                up_track,
   input  logic [IDX_W-1:0]                                   up_idx,
   output logic                                               dn_valid,
   input  logic                                               dn_ready,
   output logic [sbmt_pkg::EDGE_COUNT-1:0][COORD_BITS-1:0]    dn_edges,
   output sbmt_pkg::track_type                                dn_track,
   output logic [IDX_W-1:0]                                   dn_idx
);

   localparam int PROD_W = COORD_BITS + sbmt_pkg::COMP_W;
   localparam int PROJ_W = PROD_W + 1;
   localparam int OV_W   = PROJ_W + 1;

   logic signed [sbmt_pkg::COMP_W-1:0] ax;
   logic signed [sbmt_pkg::COMP_W-1:0] ay;

   assign ax = $signed(axis_word[sbmt_pkg::AXIS_WORD_W-1 -: sbmt_pkg::COMP_W]);
   assign ay = $signed(axis_word[sbmt_pkg::COMP_W-1:0]);

   // stage registers
   logic                                            s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                                            rdy1, rdy2, rdy3;
   logic [sbmt_pkg::EDGE_COUNT-1:0][COORD_BITS-1:0] s1_edges_ff, s2_edges_ff, s3_edges_ff;
   sbmt_pkg::track_type                             s1_track_ff, s2_track_ff, s3_track_ff;
   logic [IDX_W-1:0]                                s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic signed [PROD_W-1:0]                        prod_in [sbmt_pkg::EDGE_COUNT];
   logic signed [PROD_W-1:0]                        prod_ff [sbmt_pkg::EDGE_COUNT];
   logic signed [PROJ_W-1:0]                        lo_in [2];
   logic signed [PROJ_W-1:0]                        hi_in [2];
   logic signed [PROJ_W-1:0]                        lo_ff [2];
   logic signed [PROJ_W-1:0]                        hi_ff [2];
   sbmt_pkg::track_type                             track_in;
   logic [IDX_W-1:0]                                idx_in;

   // advance a stage when it is empty or its successor takes its item
   assign rdy3     = !s3_valid_ff || dn_ready;
   assign rdy2     = !s2_valid_ff || rdy3;
   assign rdy1     = !s1_valid_ff || rdy2;
   assign up_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff <= up_valid;
         if (rdy2) s2_valid_ff <= s1_valid_ff;
         if (rdy3) s3_valid_ff <= s2_valid_ff;
      end
   end

   // edge times axis component: left/right use x, top/bottom use y
   always_comb begin
      for (int b = 0; b < 2; b++) begin
         prod_in[b*sbmt_pkg::BOX_EDGES + sbmt_pkg::E_LEFT] =
            PROD_W'($signed(up_edges[b*sbmt_pkg::BOX_EDGES + sbmt_pkg::E_LEFT])) * PROD_W'(ax);
         prod_in[b*sbmt_pkg::BOX_EDGES + sbmt_pkg::E_RIGHT] =
            PROD_W'($signed(up_edges[b*sbmt_pkg::BOX_EDGES + sbmt_pkg::E_RIGHT])) * PROD_W'(ax);
         prod_in[b*sbmt_pkg::BOX_EDGES + sbmt_pkg::E_TOP] =
            PROD_W'($signed(up_edges[b*sbmt_pkg::BOX_EDGES + sbmt_pkg::E_TOP])) * PROD_W'(ay);
         prod_in[b*sbmt_pkg::BOX_EDGES + sbmt_pkg::E_BOTTOM] =
            PROD_W'($signed(up_edges[b*sbmt_pkg::BOX_EDGES + sbmt_pkg::E_BOTTOM])) * PROD_W'(ay);
      end
   end

   // corner projections separate into an x and a y term, so the bounds are
   // the sums of per-term bounds
   always_comb begin
      logic signed [PROD_W-1:0] pl, pr, pt, pb;
      for (int b = 0; b < 2; b++) begin
         pl = prod_ff[b*sbmt_pkg::BOX_EDGES + sbmt_pkg::E_LEFT];
         pr = prod_ff[b*sbmt_pkg::BOX_EDGES + sbmt_pkg::E_RIGHT];
         pt = prod_ff[b*sbmt_pkg::BOX_EDGES + sbmt_pkg::E_TOP];
         pb = prod_ff[b*sbmt_pkg::BOX_EDGES + sbmt_pkg::E_BOTTOM];
         lo_in[b] = PROJ_W'((pl < pr) ? pl : pr) + PROJ_W'((pt < pb) ? pt : pb);
         hi_in[b] = PROJ_W'((pl > pr) ? pl : pr) + PROJ_W'((pt > pb) ? pt : pb);
      end
   end

   // separation test and least-overlap update; touching counts as overlap
   always_comb begin
      logic              sep_here;
      logic signed [OV_W-1:0] ov;
      logic              better;
      sep_here = active && ((hi_ff[0] < lo_ff[1]) || (hi_ff[1] < lo_ff[0]));
      ov       = OV_W'(hi_ff[1]) - OV_W'(lo_ff[0]);
      better   = active && !sep_here && !s2_track_ff.sep &&
                 (ov < $signed(OV_W'(s2_track_ff.best)));
      track_in     = s2_track_ff;
      idx_in       = s2_idx_ff;
      track_in.sep = s2_track_ff.sep || sep_here;
      if (better) begin
         track_in.best = ov[sbmt_pkg::BEST_W-1:0];
         track_in.axis = axis_word;
         idx_in        = IDX_W'(CELL_IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && up_valid) begin
         s1_edges_ff <= up_edges;
         s1_track_ff <= up_track;
         s1_idx_ff   <= up_idx;
         prod_ff     <= prod_in;
      end
      if (rdy2 && s1_valid_ff) begin
         s2_edges_ff <= s1_edges_ff;
         s2_track_ff <= s1_track_ff;
         s2_idx_ff   <= s1_idx_ff;
         lo_ff       <= lo_in;
         hi_ff       <= hi_in;
      end
      if (rdy3 && s2_valid_ff) begin
         s3_edges_ff <= s2_edges_ff;
         s3_track_ff <= track_in;
         s3_idx_ff   <= idx_in;
      end
   end

   assign dn_valid = s3_valid_ff;
   assign dn_edges = s3_edges_ff;
   assign dn_track = s3_track_ff;
   assign dn_idx   = s3_idx_ff;

endmodule

`default_nettype wire

// ----- hdl/sbmt_push.sv -----
// sbmt_push: scales the least overlap by the kept axis, truncates toward zero
// and saturates into the output register. Depends on sbmt_pkg.
`default_nettype none

module sbmt_push #(
   parameter int COORD_BITS = 20,
   parameter int IDX_W      = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           up_valid,
   output logic                           up_ready,
   input  sbmt_pkg::track_type            up_track,
   input  logic [IDX_W-1:0]               up_idx,
   output logic                           dn_valid,
   input  logic                           dn_ready,
   output logic signed [COORD_BITS-1:0]   push_x,
   output logic signed [COORD_BITS-1:0]   push_y,
   output logic                           collided,
   output logic [sbmt_pkg::CHOSEN_W-1:0]  chosen_axis
);

   localparam int MUL_W = sbmt_pkg::BEST_W + 1 + sbmt_pkg::COMP_W;
   localparam int Q_W   = MUL_W - sbmt_pkg::PUSH_SHIFT;
   localparam int EXT_W = (Q_W > COORD_BITS) ? Q_W : COORD_BITS;

   logic                        m_valid_ff, o_valid_ff;
   logic                        rdy_m, rdy_o;
   logic signed [MUL_W-1:0]     mx_ff, my_ff;
   logic                        m_sep_ff;
   logic [IDX_W-1:0]            m_idx_ff;
   logic signed [MUL_W-1:0]     mx_in, my_in;
   logic signed [COORD_BITS-1:0] px_in, py_in;
   logic signed [COORD_BITS-1:0] push_x_ff, push_y_ff;
   logic                         collided_ff;
   logic [sbmt_pkg::CHOSEN_W-1:0] chosen_ff;

   function automatic logic signed [COORD_BITS-1:0] trunc_sat(input logic signed [MUL_W-1:0] p);
      logic signed [MUL_W-1:0] biased;
      logic signed [Q_W-1:0]   q;
      logic signed [EXT_W-1:0] qe, hi_lim, lo_lim, r;
      // bias negatives so the shift rounds toward zero
      biased = p + (p[MUL_W-1] ? MUL_W'((MUL_W'(1) << sbmt_pkg::PUSH_SHIFT) - MUL_W'(1))
                               : MUL_W'(0));
      q      = $signed(biased[MUL_W-1:sbmt_pkg::PUSH_SHIFT]);
      qe     = EXT_W'(q);
      hi_lim = $signed({{(EXT_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
      lo_lim = -hi_lim - EXT_W'(1);
      if (qe > hi_lim)      r = hi_lim;
      else if (qe < lo_lim) r = lo_lim;
      else                  r = qe;
      return r[COORD_BITS-1:0];
   endfunction

   assign rdy_o    = !o_valid_ff || dn_ready;
   assign rdy_m    = !m_valid_ff || rdy_o;
   assign up_ready = rdy_m;

   assign mx_in = MUL_W'($signed({1'b0, up_track.best})) *
                  MUL_W'($signed(up_track.axis[sbmt_pkg::AXIS_WORD_W-1 -: sbmt_pkg::COMP_W]));
   assign my_in = MUL_W'($signed({1'b0, up_track.best})) *
                  MUL_W'($signed(up_track.axis[sbmt_pkg::COMP_W-1:0]));

   assign px_in = trunc_sat(mx_ff);
   assign py_in = trunc_sat(my_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (rdy_m) m_valid_ff <= up_valid;
         if (rdy_o) o_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_m && up_valid) begin
         mx_ff    <= mx_in;
         my_ff    <= my_in;
         m_sep_ff <= up_track.sep;
         m_idx_ff <= up_idx;
      end
      if (rdy_o && m_valid_ff) begin
         // separated boxes give a zero result
         push_x_ff   <= m_sep_ff ? '0 : px_in;
         push_y_ff   <= m_sep_ff ? '0 : py_in;
         collided_ff <= !m_sep_ff;
         chosen_ff   <= m_sep_ff ? '0 : sbmt_pkg::CHOSEN_W'(m_idx_ff);
      end
   end

   assign dn_valid    = o_valid_ff;
   assign push_x      = push_x_ff;
   assign push_y      = push_y_ff;
   assign collided    = collided_ff;
   assign chosen_axis = chosen_ff;

endmodule

`default_nettype wire
